// ----- rtl/core/fractional_box_blur_line_unit_defines.svh -----
// Assertion macros shared by the blur line unit.
`ifndef FRACTIONAL_BOX_BLUR_LINE_UNIT_DEFINES_SVH
`define FRACTIONAL_BOX_BLUR_LINE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBB_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbb: property violated");

// The consequent must hold in the cycle after the antecedent.
`define FBB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbb: property violated");

`endif

// ----- rtl/core/fbb_pkg.sv -----
package fbb_pkg;

  localparam int PIX_W          = 16;
  localparam int CH_N           = 4;
  localparam int RAD_W          = 5;
  localparam int FRAC_W         = 6;
  localparam int SCALE_W        = 17;
  localparam int NORM_SHIFT     = 22;
  localparam int UNIT_LOG       = 6;
  localparam int UNIT           = 64;
  localparam int MAX_RADIUS_DEF = 31;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd21845;
  localparam logic [RAD_W-1:0]   WHOLE_RESET = 5'd1;
  localparam logic [FRAC_W-1:0]  FRAC_RESET  = 6'd0;

  localparam logic REG_WHOLE = 1'b0;
  localparam logic REG_FRAC  = 1'b1;

  typedef logic [CH_N-1:0][PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic push;
    logic load;
    logic ld_a;
    logic ld_b;
    logic ld_out;
  } lane_ctl_t;

endpackage

// ----- rtl/core/fbb_cell.sv -----
module fbb_cell (
  input  logic              clk,
  input  fbb_pkg::lane_ctl_t ctl,
  input  logic              is_top,
  input  fbb_pkg::pix_t     pix_new,
  input  fbb_pkg::pix_t     pix_next,
  output fbb_pkg::pix_t     pix_q
);

  // At line start every cell takes the first pixel; otherwise the top of the
  // window takes the new pixel and the rest shift toward cell zero.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pix_q <= pix_new;
    end else if (ctl.push) begin
      pix_q <= is_top ? pix_new : pix_next;
    end
  end

endmodule

// ----- rtl/core/fbb_lane.sv -----
module fbb_lane #(
  parameter int MAX_RADIUS = fbb_pkg::MAX_RADIUS_DEF
) (
  input  logic                              clk,
  input  fbb_pkg::lane_ctl_t                ctl,
  input  logic [$clog2(2*MAX_RADIUS+4)-1:0] span,
  input  logic [fbb_pkg::FRAC_W-1:0]        frac,
  input  logic [fbb_pkg::SCALE_W-1:0]       scale,
  input  logic [fbb_pkg::PIX_W-1:0]         pix_new,
  input  logic [fbb_pkg::PIX_W-1:0]         old0,
  input  logic [fbb_pkg::PIX_W-1:0]         old1,
  output logic [fbb_pkg::PIX_W-1:0]         result
);

  localparam int DEPTH  = 2 * MAX_RADIUS + 3;
  localparam int SPAN_W = $clog2(DEPTH + 1);
  localparam int W_W    = fbb_pkg::PIX_W + SPAN_W;
  localparam int S_W    = W_W + fbb_pkg::UNIT_LOG;
  localparam int P_W    = S_W + fbb_pkg::SCALE_W;
  localparam int PAIR_W = fbb_pkg::PIX_W + 1;
  localparam int EDGE_W = fbb_pkg::FRAC_W + 1;

  logic [W_W-1:0]    w;
  logic [W_W-1:0]    w_next;
  logic [W_W-1:0]    w_a;
  logic [PAIR_W-1:0] pair_a;
  logic [S_W-1:0]    s_b;
  logic [S_W-1:0]    s_next;
  logic [EDGE_W-1:0] edge_cut;
  logic [P_W-1:0]    prod;

  assign w_next = ctl.load ? W_W'(W_W'(span) * W_W'(pix_new))
                           : w + W_W'(pix_new) - W_W'(old0);

  // The window sum counts the edge pixels at full weight; take back the part
  // above the fractional edge weight.
  assign edge_cut = EDGE_W'(fbb_pkg::UNIT) - EDGE_W'(frac);
  assign s_next   = {w_a, {fbb_pkg::UNIT_LOG{1'b0}}} - S_W'(edge_cut) * S_W'(pair_a);
  assign prod     = P_W'(s_b) * P_W'(scale);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      w <= w_next;
    end
    if (ctl.ld_a) begin
      w_a    <= w_next;
      pair_a <= PAIR_W'(old1) + PAIR_W'(pix_new);
    end
    if (ctl.ld_b) begin
      s_b <= s_next;
    end
    if (ctl.ld_out) begin
      result <= prod[fbb_pkg::NORM_SHIFT +: fbb_pkg::PIX_W];
    end
  end

endmodule

// ----- rtl/core/fbb_scale_div.sv -----
module fbb_scale_div #(
  parameter int DEN_W = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DEN_W-1:0]            den,
  output logic                        busy,
  output logic [fbb_pkg::SCALE_W-1:0] scale
);

  localparam int ITER   = fbb_pkg::NORM_SHIFT + 1;
  localparam int ITER_W = $clog2(ITER + 1);

  logic [ITER_W-1:0] cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    rem_sh;
  logic              q_bit;
  logic [DEN_W-1:0]  rem_next;

  // Restoring division of a single set bit by the window weight, one quotient
  // bit per cycle.
  assign rem_sh   = {rem, (cnt == ITER_W'(ITER))};
  assign q_bit    = (rem_sh >= {1'b0, den});
  assign rem_next = q_bit ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= '0;
      rem   <= '0;
      scale <= fbb_pkg::SCALE_RESET;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= ITER_W'(ITER);
      rem   <= '0;
      scale <= '0;
    end else if (busy) begin
      rem   <= rem_next;
      scale <= {scale[fbb_pkg::SCALE_W-2:0], q_bit};
      cnt   <= cnt - ITER_W'(1);
      busy  <= (cnt != ITER_W'(1));
    end
  end

endmodule

// ----- rtl/core/fractional_box_blur_line_unit.sv -----
// Horizontal box blur of one pixel line with a fractional radius r + a/64,
// applied to four 16-bit channels. Pixels enter one per cycle, unless
// in_stall holds them, into a chain of 2*MAX_RADIUS+3 window cells that
// keeps a running sum per channel, and each result passes through the
// window sum, edge-corrected sum and output registers after the pixel that
// completes its window, r+1 pixels behind the input. The request marked
// line_end then holds the input while r+1 copies of the last pixel flush the
// remaining results. A register write restarts the line and holds the input
// while the scale factor is divided out one bit per cycle. Results are
// sum * scale >> 22 with the scale set to floor(2^22 / (64*(2r+1) + 2a)).
`include "fractional_box_blur_line_unit_defines.svh"

module fractional_box_blur_line_unit #(
  parameter int MAX_RADIUS = fbb_pkg::MAX_RADIUS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fbb_pkg::PIX_W-1:0]  in_red,
  input  logic [fbb_pkg::PIX_W-1:0]  in_green,
  input  logic [fbb_pkg::PIX_W-1:0]  in_blue,
  input  logic [fbb_pkg::PIX_W-1:0]  in_alpha,
  input  logic                       line_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fbb_pkg::PIX_W-1:0]  out_red,
  output logic [fbb_pkg::PIX_W-1:0]  out_green,
  output logic [fbb_pkg::PIX_W-1:0]  out_blue,
  output logic [fbb_pkg::PIX_W-1:0]  out_alpha,
  output logic                       out_line_end,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fbb_pkg::ADDR_W-1:0] paddr,
  input  logic [fbb_pkg::DATA_W-1:0] pwdata,
  output logic [fbb_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int DEPTH  = 2 * MAX_RADIUS + 3;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SPAN_W = $clog2(DEPTH + 1);
  localparam int CNT_W  = $clog2(MAX_RADIUS + 2);
  localparam int DEN_W  = $clog2(fbb_pkg::UNIT * (2 * MAX_RADIUS + 1)
                                 + 2 * (2 ** fbb_pkg::FRAC_W - 1) + 1);
  localparam int RAD_W  = fbb_pkg::RAD_W;

  logic [RAD_W-1:0]              radius_whole;
  logic [fbb_pkg::FRAC_W-1:0]    radius_frac;
  logic [RAD_W-1:0]              r_eff;
  logic [IDX_W-1:0]              top_idx;
  logic [SPAN_W-1:0]             span;
  logic [CNT_W-1:0]              r_plus1;
  logic [DEN_W-1:0]              den;
  logic [fbb_pkg::SCALE_W-1:0]   scale;
  logic                          div_go;
  logic                          div_busy;

  fbb_pkg::state_t               state;
  fbb_pkg::state_t               state_next;
  logic [CNT_W-1:0]              flush_cnt;
  logic [CNT_W-1:0]              fill;
  logic [CNT_W-1:0]              fill_next;
  logic                          line_start;
  fbb_pkg::pix_t                 last_pix;
  fbb_pkg::pix_t                 in_pix;
  fbb_pkg::pix_t                 push_pix;
  fbb_pkg::pix_t                 cell_q [DEPTH];
  fbb_pkg::pix_t                 res;

  logic                          cfg_wr;
  logic                          accept;
  logic                          flush_push;
  logic                          last_copy;
  logic                          emit;
  logic                          va;
  logic                          vb;
  logic                          le_a;
  logic                          le_b;
  logic                          rdy_out;
  logic                          rdy_b;
  logic                          rdy_a;
  fbb_pkg::lane_ctl_t            ctl;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      fbb_pkg::REG_WHOLE: prdata = fbb_pkg::DATA_W'(radius_whole);
      fbb_pkg::REG_FRAC:  prdata = fbb_pkg::DATA_W'(radius_frac);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_whole <= fbb_pkg::WHOLE_RESET;
      radius_frac  <= fbb_pkg::FRAC_RESET;
      div_go       <= 1'b0;
    end else begin
      div_go <= cfg_wr;
      if (cfg_wr && (paddr[2] == fbb_pkg::REG_WHOLE)) begin
        radius_whole <= pwdata[RAD_W-1:0];
      end
      if (cfg_wr && (paddr[2] == fbb_pkg::REG_FRAC)) begin
        radius_frac <= pwdata[fbb_pkg::FRAC_W-1:0];
      end
    end
  end

  assign r_eff   = (radius_whole > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_whole;
  assign top_idx = IDX_W'({r_eff, 1'b0}) + IDX_W'(2);
  assign span    = SPAN_W'({r_eff, 1'b0}) + SPAN_W'(3);
  assign r_plus1 = CNT_W'(r_eff) + CNT_W'(1);
  assign den     = (DEN_W'({r_eff, 1'b1}) << fbb_pkg::UNIT_LOG) + DEN_W'({radius_frac, 1'b0});

  fbb_scale_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .den   (den),
    .busy  (div_busy),
    .scale (scale)
  );

  // Handshake and pipeline flow.
  assign rdy_out    = !out_valid || !out_stall;
  assign rdy_b      = !vb || rdy_out;
  assign rdy_a      = !va || rdy_b;
  assign in_stall   = (state != fbb_pkg::ST_RUN) || !rdy_a;
  assign accept     = in_valid && !in_stall;
  assign flush_push = (state == fbb_pkg::ST_FLUSH) && rdy_a;
  assign last_copy  = flush_push && (flush_cnt == CNT_W'(1));

  assign in_pix[0] = in_red;
  assign in_pix[1] = in_green;
  assign in_pix[2] = in_blue;
  assign in_pix[3] = in_alpha;
  assign push_pix  = (state == fbb_pkg::ST_FLUSH) ? last_pix : in_pix;

  assign ctl.push   = accept || flush_push;
  assign ctl.load   = accept && line_start;
  assign fill_next  = ctl.load ? '0 : ((fill == r_plus1) ? fill : fill + CNT_W'(1));
  assign emit       = ctl.push && !ctl.load && (fill_next == r_plus1);
  assign ctl.ld_a   = emit;
  assign ctl.ld_b   = va && rdy_b;
  assign ctl.ld_out = vb && rdy_out;

  always_comb begin
    state_next = state;
    case (state)
      fbb_pkg::ST_RUN: begin
        if (accept && line_end) begin
          state_next = fbb_pkg::ST_FLUSH;
        end
      end
      fbb_pkg::ST_FLUSH: begin
        if (last_copy) begin
          state_next = fbb_pkg::ST_RUN;
        end
      end
      fbb_pkg::ST_DIV: begin
        if (!div_go && !div_busy) begin
          state_next = fbb_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = fbb_pkg::ST_RUN;
      end
    endcase
    if (cfg_wr) begin
      state_next = fbb_pkg::ST_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fbb_pkg::ST_RUN;
      flush_cnt  <= '0;
      fill       <= '0;
      line_start <= 1'b1;
      va         <= 1'b0;
      vb         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && line_end) begin
        flush_cnt <= r_plus1;
      end else if (flush_push) begin
        flush_cnt <= flush_cnt - CNT_W'(1);
      end
      if (cfg_wr) begin
        fill <= '0;
      end else if (ctl.push) begin
        fill <= fill_next;
      end
      if (cfg_wr || last_copy) begin
        line_start <= 1'b1;
      end else if (accept) begin
        line_start <= 1'b0;
      end
      if (rdy_a) begin
        va <= emit;
      end
      if (rdy_b) begin
        vb <= va;
      end
      if (rdy_out) begin
        out_valid <= vb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_pix <= in_pix;
    end
    if (ctl.ld_a) begin
      le_a <= last_copy;
    end
    if (ctl.ld_b) begin
      le_b <= le_a;
    end
    if (ctl.ld_out) begin
      out_line_end <= le_b;
    end
  end

  // Window cells: cell zero holds the oldest pixel of the window.
  genvar k;
  for (k = 0; k < DEPTH; k++) begin : g_cell
    fbb_pkg::pix_t nxt;
    if (k == DEPTH - 1) begin : g_last
      assign nxt = push_pix;
    end else begin : g_mid
      assign nxt = cell_q[k+1];
    end
    fbb_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .is_top   (top_idx == IDX_W'(k)),
      .pix_new  (push_pix),
      .pix_next (nxt),
      .pix_q    (cell_q[k])
    );
  end

  genvar c;
  for (c = 0; c < fbb_pkg::CH_N; c++) begin : g_lane
    fbb_lane #(
      .MAX_RADIUS (MAX_RADIUS)
    ) u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .span    (span),
      .frac    (radius_frac),
      .scale   (scale),
      .pix_new (push_pix[c]),
      .old0    (cell_q[0][c]),
      .old1    (cell_q[1][c]),
      .result  (res[c])
    );
  end

  assign out_red   = res[0];
  assign out_green = res[1];
  assign out_blue  = res[2];
  assign out_alpha = res[3];

  `FBB_ASSERT_NEXT(a_cfg_holds_input, clk, rst, cfg_wr, in_stall)
  `FBB_ASSERT_SAME(a_fill_bounded, clk, rst, 1'b1, fill <= r_plus1)
  `FBB_ASSERT_SAME(a_flush_counts, clk, rst, state == fbb_pkg::ST_FLUSH, flush_cnt != '0)

endmodule
